### rtl/slt_pkg.sv
// ----------------------------------------------------------------------------
// slt_pkg
// Shared types, widths and codes for the shared/exclusive lock table.
// ----------------------------------------------------------------------------
`default_nettype none

package slt_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

    localparam int KIND_W   = 2;
    localparam int OWNER_W  = 32;
    localparam int KEY_W    = 64;
    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;
    localparam int FREED_W  = 5;

    localparam int IN_TDATA_W  = ((OWNER_W + KEY_W + MODE_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((FREED_W + 7) / 8) * 8;

    localparam logic [FREED_W-1:0] FREED_MAX = '1;
    localparam int MAX_RELEASED = (TABLE_ENTRIES < 31) ? TABLE_ENTRIES : 31;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [MODE_W-1:0] MODE_SHARED    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_EXCLUSIVE = 2'd2;

    typedef enum logic [KIND_W-1:0] {
        OP_ACQUIRE     = 2'd0,
        OP_UNLOCK      = 2'd1,
        OP_RELEASE_ALL = 2'd2,
        OP_INVALID     = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 2'd0,
        ST_CONFLICT  = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef struct packed {
        logic [OWNER_W-1:0] owner;
        logic [KEY_W-1:0]   key;
        logic [MODE_W-1:0]  mode;
    } t_entry;

    // cmask[m] set: a held lock of mode m blocks this request
    typedef struct packed {
        t_op                      op;
        t_entry                   ent;
        logic [(1<<MODE_W)-1:0]   cmask;
    } t_req;

    typedef struct packed {
        t_status             status;
        logic [FREED_W-1:0]  freed;
    } t_rsp;

    function automatic logic [(1<<MODE_W)-1:0] conflict_mask(logic [MODE_W-1:0] mode);
        logic [(1<<MODE_W)-1:0] m;
        m = '0;
        if (mode == MODE_EXCLUSIVE) begin
            m = '1;
            m[0] = 1'b0;
        end else if (mode == MODE_SHARED) begin
            m[MODE_EXCLUSIVE] = 1'b1;
        end
        return m;
    endfunction

endpackage

`default_nettype wire

### rtl/slt_front.sv
// ----------------------------------------------------------------------------
// slt_front
// Input stage: unpacks a request, decodes its kind and conflict mask.
// ----------------------------------------------------------------------------
`default_nettype none

module slt_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [slt_pkg::IN_TDATA_W-1:0] i_data,
    input  wire logic [slt_pkg::KIND_W-1:0]    i_kind,
    output logic                               o_req_valid,
    input  wire logic                          i_req_ready,
    output slt_pkg::t_req                      o_req
);
    import slt_pkg::*;

    logic r_valid, n_valid;
    t_req r_req, n_req;
    logic load;

    assign o_ready = !r_valid || i_req_ready;
    assign load    = i_valid && o_ready;

    always_comb begin
        n_valid = r_valid;
        if (load) begin
            n_valid = 1'b1;
        end else if (i_req_ready) begin
            n_valid = 1'b0;
        end
        n_req           = r_req;
        if (load) begin
            n_req.op        = t_op'(i_kind);
            n_req.ent.owner = i_data[OWNER_W-1:0];
            n_req.ent.key   = i_data[OWNER_W +: KEY_W];
            n_req.ent.mode  = i_data[OWNER_W+KEY_W +: MODE_W];
            n_req.cmask     = conflict_mask(i_data[OWNER_W+KEY_W +: MODE_W]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req <= n_req;
    end

    assign o_req_valid = r_valid;
    assign o_req       = r_req;

endmodule

`default_nettype wire

### rtl/slt_queue.sv
// ----------------------------------------------------------------------------
// slt_queue
// Short request queue between the front stage and the table engine.
// ----------------------------------------------------------------------------
`default_nettype none

module slt_queue (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_ready,
    input  wire slt_pkg::t_req i_req,
    output logic         o_valid,
    input  wire logic    i_pop,
    output slt_pkg::t_req o_req
);
    import slt_pkg::*;

    t_req              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp, n_wp;
    logic [QPTR_W-1:0] r_rp, n_rp;
    logic [QCNT_W-1:0] r_cnt, n_cnt;
    logic              push, pop;

    assign o_ready = (r_cnt != QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign push    = i_valid && o_ready;
    assign pop     = i_pop && o_valid;
    assign o_req   = r_slot[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (push) begin
            n_wp = (r_wp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + QPTR_W'(1);
        end
        if (pop) begin
            n_rp = (r_rp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + QPTR_W'(1);
        end
        if (push && !pop) begin
            n_cnt = r_cnt + QCNT_W'(1);
        end else if (pop && !push) begin
            n_cnt = r_cnt - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wp] <= i_req;
        end
    end

endmodule

`default_nettype wire

### rtl/slt_engine.sv
// ----------------------------------------------------------------------------
// slt_engine
// Table engine: scans the lock memory one entry per cycle, compacts it on
// removals, appends on grants and holds the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module slt_engine (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_req_valid,
    output logic          o_req_pop,
    input  wire slt_pkg::t_req i_req,
    output logic          o_rsp_valid,
    input  wire logic     i_rsp_ready,
    output slt_pkg::t_rsp o_rsp
);
    import slt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_FINISH = 3'b100
    } t_state;

    t_entry r_mem [TABLE_ENTRIES];
    t_entry r_q;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_rd, n_rd;
    logic [CNT_W-1:0]   r_wr, n_wr;
    logic               r_rd_valid, n_rd_valid;
    logic               r_conflict, n_conflict;
    logic               r_dropped, n_dropped;
    logic [FREED_W-1:0] r_freed, n_freed;
    t_req               r_req, n_req;
    logic               r_out_valid, n_out_valid;
    t_rsp               r_out, n_out;

    logic               we, re, drop, own, same;
    logic [IDX_W-1:0]   waddr, raddr;
    t_entry             wdata;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_rd        = r_rd;
        n_wr        = r_wr;
        n_rd_valid  = r_rd_valid;
        n_conflict  = r_conflict;
        n_dropped   = r_dropped;
        n_freed     = r_freed;
        n_req       = r_req;
        n_out_valid = r_out_valid && !i_rsp_ready;
        n_out       = r_out;
        o_req_pop   = 1'b0;
        we          = 1'b0;
        re          = 1'b0;
        waddr       = r_wr[IDX_W-1:0];
        raddr       = r_rd[IDX_W-1:0];
        wdata       = r_q;
        drop        = 1'b0;
        own         = (r_q.owner == r_req.ent.owner);
        same        = (r_q.key == r_req.ent.key);

        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_req_pop  = 1'b1;
                    n_req      = i_req;
                    n_rd       = '0;
                    n_wr       = '0;
                    n_rd_valid = 1'b0;
                    n_conflict = 1'b0;
                    n_dropped  = 1'b0;
                    n_freed    = '0;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_rd_valid) begin
                    unique case (r_req.op)
                        OP_ACQUIRE: begin
                            if (same && !own && r_req.cmask[r_q.mode]) begin
                                n_conflict = 1'b1;
                            end
                        end
                        OP_UNLOCK:      drop = own && same && !r_dropped;
                        OP_RELEASE_ALL: drop = own;
                        default:        drop = 1'b0;
                    endcase
                    if (drop) begin
                        n_dropped = 1'b1;
                        if (r_freed != FREED_MAX) begin
                            n_freed = r_freed + FREED_W'(1);
                        end
                    end else if (r_req.op == OP_UNLOCK || r_req.op == OP_RELEASE_ALL) begin
                        we   = 1'b1;
                        n_wr = r_wr + CNT_W'(1);
                    end
                end
                if (r_rd != r_count) begin
                    re         = 1'b1;
                    n_rd       = r_rd + CNT_W'(1);
                    n_rd_valid = 1'b1;
                end else begin
                    n_rd_valid = 1'b0;
                    if (!r_rd_valid) begin
                        n_state = S_FINISH;
                    end
                end
            end
            S_FINISH: begin
                if (!r_out_valid || i_rsp_ready) begin
                    n_out_valid = 1'b1;
                    n_out.freed = '0;
                    n_state     = S_IDLE;
                    unique case (r_req.op)
                        OP_ACQUIRE: begin
                            if (r_conflict) begin
                                n_out.status = ST_CONFLICT;
                            end else if (r_count == CNT_W'(TABLE_ENTRIES)) begin
                                n_out.status = ST_FULL;
                            end else begin
                                n_out.status = ST_DONE;
                                we      = 1'b1;
                                waddr   = r_count[IDX_W-1:0];
                                wdata   = r_req.ent;
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        OP_UNLOCK: begin
                            n_out.status = r_dropped ? ST_DONE : ST_NOT_FOUND;
                            n_out.freed  = r_freed;
                            n_count      = r_wr;
                        end
                        OP_RELEASE_ALL: begin
                            n_out.status = ST_DONE;
                            n_out.freed  = r_freed;
                            n_count      = r_wr;
                        end
                        default: begin
                            n_out.status = ST_NOT_FOUND;
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rd        <= '0;
            r_wr        <= '0;
            r_rd_valid  <= 1'b0;
            r_conflict  <= 1'b0;
            r_dropped   <= 1'b0;
            r_freed     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rd        <= n_rd;
            r_wr        <= n_wr;
            r_rd_valid  <= n_rd_valid;
            r_conflict  <= n_conflict;
            r_dropped   <= n_dropped;
            r_freed     <= n_freed;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_out <= n_out;
    end

    // compaction writes always land below the read pointer
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (re) begin
            r_q <= r_mem[raddr];
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

endmodule

`default_nettype wire

### rtl/shared_exclusive_lock_table.sv
// ----------------------------------------------------------------------------
// shared_exclusive_lock_table
// Lock table with shared and exclusive modes: acquire, unlock, release-all.
//
//  channel   dir  handshake              payload
//  s_axis    in   tvalid/tready          tuser kind, tdata owner/key/mode
//  m_axis    out  tvalid/tready          tuser status, tdata released count
//
// The engine reads the N held locks of the lock memory one entry per cycle
// through its single read port, then commits in its finish state once the
// output register is free. Reset empties the table at once. Two queued
// requests plus the front register absorb output stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module shared_exclusive_lock_table (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [31:0] requester_id, [95:32] resource_key, [97:96] lock_mode
    input  wire logic [slt_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // [1:0] kind
    input  wire logic [slt_pkg::KIND_W-1:0]      s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // [4:0] released_count
    output logic [slt_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    // [1:0] status
    output logic [slt_pkg::STATUS_W-1:0]         m_axis_tuser
);
    import slt_pkg::*;

    logic front_valid, queue_ready, queue_valid, pop;
    t_req front_req, queue_req;
    t_rsp rsp;

    slt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_data      (s_axis_tdata),
        .i_kind      (s_axis_tuser),
        .o_req_valid (front_valid),
        .i_req_ready (queue_ready),
        .o_req       (front_req)
    );

    slt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_ready (queue_ready),
        .i_req   (front_req),
        .o_valid (queue_valid),
        .i_pop   (pop),
        .o_req   (queue_req)
    );

    slt_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (queue_valid),
        .o_req_pop   (pop),
        .i_req       (queue_req),
        .o_rsp_valid (m_axis_tvalid),
        .i_rsp_ready (m_axis_tready),
        .o_rsp       (rsp)
    );

    assign m_axis_tdata = OUT_TDATA_W'(rsp.freed);
    assign m_axis_tuser = rsp.status;

endmodule

`default_nettype wire

### rtl/slt_checker.sv
// ----------------------------------------------------------------------------
// slt_checker
// Port-level checks for the lock table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module slt_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            m_axis_tvalid,
    input wire logic                            m_axis_tready,
    input wire logic [slt_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input wire logic [slt_pkg::STATUS_W-1:0]    m_axis_tuser
);
    import slt_pkg::*;

    logic [FREED_W-1:0] freed;
    assign freed = m_axis_tdata[FREED_W-1:0];

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> freed <= FREED_W'(MAX_RELEASED))
        else $error("released count above table size");

    a_fail_no_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_CONFLICT || m_axis_tuser == ST_FULL ||
            m_axis_tuser == ST_NOT_FOUND) |-> freed == '0)
        else $error("failed request reports freed entries");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:FREED_W] == '0)
        else $error("result padding not zero");

endmodule

bind shared_exclusive_lock_table slt_checker u_slt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
